// File: hw/rtl/bleadp_pkg.sv
// ----------------------------------------------------------------------------
// bleadp_pkg
// Shared types and constants for the advertising-data structure parser.
// ----------------------------------------------------------------------------
package bleadp_pkg;

   // Default end-of-payload byte limit
   localparam int MAX_PAYLOAD_DEF = 31;

   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
   localparam logic [CNT_W-1:0] LEN_CAP = 5'd31;

   // AD types and 16-bit service UUIDs of interest
   localparam logic [7:0]  T_SERVICE16 = 8'h16;
   localparam logic [7:0]  T_NAME      = 8'h09;
   localparam logic [15:0] U_THERMO    = 16'h1809;
   localparam logic [15:0] U_BATTERY   = 16'h180F;

   // Result kind codes
   localparam logic [2:0] KIND_OTHER   = 3'd0;
   localparam logic [2:0] KIND_NAME    = 3'd1;
   localparam logic [2:0] KIND_SERVICE = 3'd2;
   localparam logic [2:0] KIND_THERMO  = 3'd3;
   localparam logic [2:0] KIND_BATTERY = 3'd4;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  ad_type;
      logic [4:0]  struct_length;
      logic [2:0]  kind;
      logic [15:0] uuid16;
      logic [7:0]  battery_level;
      logic [23:0] temperature_hundredths;
      logic        value_valid;
      logic [4:0]  bytes_consumed;
      logic        payload_end;
   } rsp_type;

endpackage

// File: hw/rtl/bleadp_core.sv
// ----------------------------------------------------------------------------
// bleadp_core
// Parse state and combinational step logic: one payload byte per fire.
// ----------------------------------------------------------------------------
module bleadp_core #(
   parameter int MAX_PAYLOAD = bleadp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  bleadp_pkg::req_type item,
   output logic              has_result,
   output bleadp_pkg::rsp_type result
);
   import bleadp_pkg::*;

   phase_type   phase_ff, phase_in, e_phase;
   logic [4:0]  len_ff, len_in, e_len;
   logic [4:0]  left_ff, left_in, e_left, left_dec;
   logic [7:0]  type_ff, type_in, e_type;
   logic [4:0]  idx_ff, idx_in, e_idx;
   logic [15:0] uuid_ff, uuid_in, e_uuid;
   logic [23:0] value_ff, value_in, e_value;
   logic [4:0]  cnt_ff, cnt_in, e_cnt, cnt_inc;
   logic        done_ff, done_in, e_done;
   logic        emit, end_flag, lim;
   logic [7:0]  b;
   logic [4:0]  after;

   // first_byte restarts from the reset state
   always_comb begin
      b       = item.data_byte;
      e_phase = item.first_byte ? PH_LEN : phase_ff;
      e_len   = item.first_byte ? '0 : len_ff;
      e_left  = item.first_byte ? '0 : left_ff;
      e_type  = item.first_byte ? '0 : type_ff;
      e_idx   = item.first_byte ? '0 : idx_ff;
      e_uuid  = item.first_byte ? '0 : uuid_ff;
      e_value = item.first_byte ? '0 : value_ff;
      e_cnt   = item.first_byte ? '0 : cnt_ff;
      e_done  = item.first_byte ? 1'b0 : done_ff;
   end

   assign cnt_inc  = (e_cnt < CNT_MAX) ? e_cnt + 5'd1 : e_cnt;
   assign lim      = 32'(cnt_inc) >= 32'(MAX_PAYLOAD);
   assign left_dec = (e_left != 5'd0) ? e_left - 5'd1 : e_left;

   // Next state
   always_comb begin
      phase_in = e_phase;
      len_in   = e_len;
      left_in  = e_left;
      type_in  = e_type;
      idx_in   = e_idx;
      uuid_in  = e_uuid;
      value_in = e_value;
      cnt_in   = e_cnt;
      done_in  = e_done;
      emit     = 1'b0;
      end_flag = 1'b0;
      if (!e_done) begin
         cnt_in = cnt_inc;
         if (e_phase == PH_LEN) begin
            type_in  = '0;
            idx_in   = '0;
            uuid_in  = '0;
            value_in = '0;
            if (b == 8'd0) begin
               len_in   = '0;
               left_in  = '0;
               done_in  = 1'b1;
               emit     = 1'b1;
               end_flag = 1'b1;
            end else begin
               len_in   = (b > 8'(LEN_CAP)) ? LEN_CAP : b[4:0];
               left_in  = (b > 8'(LEN_CAP)) ? LEN_CAP : b[4:0];
               phase_in = PH_TYPE;
               if (lim) begin
                  done_in  = 1'b1;
                  emit     = 1'b1;
                  end_flag = 1'b1;
               end
            end
         end else begin
            if (e_phase == PH_TYPE) begin
               type_in = b;
            end else begin
               case (e_idx)
                  5'd0: uuid_in = e_uuid | {8'h00, b};
                  5'd1: uuid_in = e_uuid | {b, 8'h00};
                  5'd2: value_in = e_value | {16'h0000, b};
                  5'd3: value_in = e_value | {8'h00, b, 8'h00};
                  5'd4: value_in = e_value | {b, 16'h0000};
                  default: ;
               endcase
               idx_in = (e_idx < 5'd31) ? e_idx + 5'd1 : e_idx;
            end
            left_in  = left_dec;
            phase_in = PH_DATA;
            if (left_dec == 5'd0 || lim) begin
               phase_in = PH_LEN;
               emit     = 1'b1;
               end_flag = lim;
               if (lim) begin
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   // Result decode from the updated state
   always_comb begin
      after      = (idx_in > 5'd2) ? idx_in - 5'd2 : 5'd0;
      has_result = emit;
      result     = '0;
      result.ad_type        = type_in;
      result.struct_length  = len_in;
      result.bytes_consumed = cnt_in;
      result.payload_end    = end_flag;
      if (type_in == T_NAME) begin
         result.kind = KIND_NAME;
      end else if (type_in == T_SERVICE16) begin
         result.uuid16 = uuid_in;
         if (uuid_in == U_THERMO) begin
            result.kind = KIND_THERMO;
            if (after >= 5'd3) begin
               result.value_valid            = 1'b1;
               result.temperature_hundredths = value_in;
            end
         end else if (uuid_in == U_BATTERY) begin
            result.kind = KIND_BATTERY;
            if (after >= 5'd1) begin
               result.value_valid   = 1'b1;
               result.battery_level = value_in[7:0];
            end
         end else begin
            result.kind = KIND_SERVICE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         len_ff   <= '0;
         left_ff  <= '0;
         type_ff  <= '0;
         idx_ff   <= '0;
         uuid_ff  <= '0;
         value_ff <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         type_ff  <= type_in;
         idx_ff   <= idx_in;
         uuid_ff  <= uuid_in;
         value_ff <= value_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

endmodule

// File: hw/rtl/bleadp_out_stage.sv
// ----------------------------------------------------------------------------
// bleadp_out_stage
// Result register with valid/stall handshake towards the consumer.
// ----------------------------------------------------------------------------
module bleadp_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bleadp_pkg::rsp_type result,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bleadp_pkg::rsp_type rsp_data
);
   import bleadp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

// File: hw/rtl/ble_adv_data_parser.sv
// A result passes the input register, then the result register, onto rsp_data.
// Throughput: one payload byte per cycle while no result is blocked; an input register
//   feeds the step logic and a result register decouples the consumer.
// A stall on rsp_ holds the next byte only if that byte produces a result.
// Reset (synchronous, active high) returns the parse to "expect length byte";
//   payload registers are not cleared.
// ----------------------------------------------------------------------------
// ble_adv_data_parser
// Walks length-type-data structures of an advertising payload, one byte per
// request, and reports each completed structure, and the payload end, with decoded fields.
// ----------------------------------------------------------------------------
module ble_adv_data_parser #(
   parameter int MAX_PAYLOAD = bleadp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bleadp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bleadp_pkg::rsp_type rsp_data
);
   import bleadp_pkg::*;

   // Input register: holds one request awaiting the step logic
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   logic    has_result;
   rsp_type result;
   logic    out_free;
   logic    advance;

   // A byte with no result never waits for the result register
   assign advance     = in_valid_ff && (!has_result || out_free);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   bleadp_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_data_ff),
      .has_result (has_result),
      .result     (result)
   );

   bleadp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A held request means a result is blocked by the consumer
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request held without a blocked result");

   // Decoded values only for thermometer or battery
   a_valid_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.value_valid) |->
         (rsp_data.kind == KIND_THERMO || rsp_data.kind == KIND_BATTERY))
      else $error("value_valid on a kind without a value");

   // UUID only reported for 16-bit service data
   a_uuid_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ad_type != T_SERVICE16) |-> (rsp_data.uuid16 == 16'h0000))
      else $error("uuid16 set on a non service-data structure");

   // Temperature only for a valid thermometer reading
   a_temp_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_data.kind == KIND_THERMO && rsp_data.value_valid)) |->
         (rsp_data.temperature_hundredths == 24'h000000))
      else $error("temperature set outside a valid thermometer result");

endmodule
